[rtl/tccw_pkg.sv]
// Package for the text console cursor writer: screen geometry, field widths,
// operation and register codes, and the classified command and result types.
// No dependencies.
`default_nettype none

package tccw_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;

    // Field widths
    localparam int OP_W     = 2;
    localparam int CHAR_W   = 8;
    localparam int TROW_W   = 6;
    localparam int TCOL_W   = 7;
    localparam int ATTR_W   = 8;
    localparam int IDX_W    = 11;
    localparam int ROW_W    = 5;
    localparam int COL_W    = 7;
    localparam int COLOR_W  = 4;
    localparam int CFG_IDX_W = 1;
    localparam int PROD_W   = 13;

    // Constants derived from the geometry
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

    // Character codes
    localparam logic [CHAR_W-1:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [CHAR_W-1:0] BLANK_BYTE   = 8'h20;

    // Reset colors
    localparam logic [COLOR_W-1:0] FG_RESET = 4'hF;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_BACK  = 2'd1,
        OP_AT    = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOREGROUND = 1'b0,
        CFG_BACKGROUND = 1'b1
    } cfg_idx_t;

    // What the back end has to do with one command
    typedef enum logic [2:0] {
        K_PUT     = 3'd0,   // write character at cursor, advance
        K_NEWLINE = 3'd1,   // move to start of next row
        K_BACK    = 3'd2,   // blank at cursor, step back
        K_AT      = 3'd3,   // write at explicit cell
        K_SKIP    = 3'd4,   // explicit cell off screen, nothing to do
        K_CLEAR   = 3'd5    // home cursor, request blank fill
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [CHAR_W-1:0]   ch;
        logic [IDX_W-1:0]    at_index;
        logic [ATTR_W-1:0]   at_attr;
    } entry_t;

    typedef struct packed {
        logic                write_enable;
        logic [IDX_W-1:0]    cell_index;
        logic [CHAR_W-1:0]   cell_char;
        logic [ATTR_W-1:0]   cell_attr;
        logic                clear_request;
        logic [ROW_W-1:0]    cursor_row_out;
        logic [COL_W-1:0]    cursor_col_out;
    } result_t;

    // Front-to-queue push
    typedef struct packed {
        logic   push;
        entry_t entry;
    } push_t;

    // Queue-to-back head
    typedef struct packed {
        logic   empty;
        entry_t entry;
    } head_t;

endpackage

`default_nettype wire

[rtl/tccw_if.sv]
// Channel interfaces of the text console cursor writer: command channel and
// result channel, each valid/ready with its payload. Depends on tccw_pkg.
`default_nettype none

interface tccw_cmd_if
    import tccw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] character;
    logic [TROW_W-1:0] target_row;
    logic [TCOL_W-1:0] target_column;
    logic [ATTR_W-1:0] cell_color;

    modport source (
        output valid, op, character, target_row, target_column, cell_color,
        input  ready
    );
    modport sink (
        input  valid, op, character, target_row, target_column, cell_color,
        output ready
    );
endinterface

interface tccw_res_if
    import tccw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              write_enable;
    logic [IDX_W-1:0]  cell_index;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
    logic              clear_request;
    logic [ROW_W-1:0]  cursor_row_out;
    logic [COL_W-1:0]  cursor_col_out;

    modport source (
        output valid, write_enable, cell_index, cell_char, cell_attr,
               clear_request, cursor_row_out, cursor_col_out,
        input  ready
    );
    modport sink (
        input  valid, write_enable, cell_index, cell_char, cell_attr,
               clear_request, cursor_row_out, cursor_col_out,
        output ready
    );
endinterface

`default_nettype wire

[rtl/text_console_cursor_writer.sv]
// Top level of the text console cursor writer: wires front end, queue and
// back end together. Depends on tccw_pkg, tccw_if, tccw_front, tccw_queue, tccw_back.
`default_nettype none

// Text console cursor writer. Each command transaction on cmd (put character,
// backspace, write at cell, clear screen) yields exactly one result transaction
// on res, in order: a cell write (index = row * COLUMNS + column, character,
// attribute) or none, a clear request, and the cursor position after the
// command. The block sustains one command per clock cycle while res.ready is
// high; that figure is set by the back end, which updates the cursor registers
// on each pop. A two-entry queue parts the front end (decode, newline detection
// and range check of write-at) from the back end, and the registered result
// lets a new command enter while an earlier result still waits on res.ready.
// The colors are written through cfg_we/cfg_index/cfg_data (index 0 foreground,
// 1 background); the user must write them only while no command is in flight,
// which the block does not enforce. There is no clearing pass after reset: the
// block accepts commands from the first cycle.

module text_console_cursor_writer
    import tccw_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COLOR_W-1:0]   cfg_data,
    tccw_cmd_if.sink                  cmd,
    tccw_res_if.source                res
);

    push_t push;
    head_t head;
    logic  q_full;
    logic  pop;

    // Classify each accepted transaction into a queue entry
    tccw_front u_front (
        .cmd    (cmd),
        .q_full (q_full),
        .push_o (push)
    );

    // Hold classified commands until the back end can take them
    tccw_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push_i (push),
        .pop    (pop),
        .full   (q_full),
        .head_o (head)
    );

    // Advance the cursor and register the result
    tccw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .head_i    (head),
        .pop       (pop),
        .res       (res)
    );

endmodule

`default_nettype wire

[rtl/tccw_front.sv]
// Front end: accepts commands and classifies them into queue entries,
// including the range check and cell index of write-at. Depends on tccw_pkg, tccw_if.
`default_nettype none

module tccw_front
    import tccw_pkg::*;
(
    tccw_cmd_if.sink   cmd,
    input  wire logic  q_full,
    output push_t      push_o
);

    logic [PROD_W-1:0] at_prod;
    logic              at_in_range;
    entry_t            entry;

    assign at_prod     = PROD_W'(cmd.target_row) * PROD_W'(COLUMNS)
                       + PROD_W'(cmd.target_column);
    assign at_in_range = (32'(cmd.target_row) < ROWS) && (32'(cmd.target_column) < COLUMNS);

    always_comb
    begin
        entry          = '0;
        entry.ch       = cmd.character;
        entry.at_attr  = cmd.cell_color;
        entry.at_index = at_prod[IDX_W-1:0];
        unique case (op_t'(cmd.op))
            OP_PUT:   entry.kind = (cmd.character == NEWLINE_BYTE) ? K_NEWLINE : K_PUT;
            OP_BACK:  entry.kind = K_BACK;
            OP_AT:    entry.kind = at_in_range ? K_AT : K_SKIP;
            OP_CLEAR: entry.kind = K_CLEAR;
        endcase
    end

    // Take a transaction whenever the queue has room
    assign cmd.ready    = !q_full;
    assign push_o.push  = cmd.valid && !q_full;
    assign push_o.entry = entry;

endmodule

`default_nettype wire

[rtl/tccw_queue.sv]
// Short queue between front and back end of the text console cursor writer.
// Depends on tccw_pkg.
`default_nettype none

module tccw_queue
    import tccw_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire push_t push_i,
    input  wire logic  pop,
    output logic       full,
    output head_t      head_o
);

    entry_t            entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_push = push_i.push && !full;
    assign do_pop  = pop && (count_reg != '0);

    assign head_o.empty = (count_reg == '0);
    assign head_o.entry = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_i.entry;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> !do_pop)
        else $error("pop from empty queue");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a push");

endmodule

`default_nettype wire

[rtl/tccw_back.sv]
// Back end: holds the cursor and color registers, carries out queued commands
// and registers one result per command. Depends on tccw_pkg, tccw_if.
`default_nettype none

module tccw_back
    import tccw_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COLOR_W-1:0]   cfg_data,
    input  wire head_t                head_i,
    output logic                      pop,
    tccw_res_if.source                res
);

    logic [ROW_W-1:0]   cursor_row_reg;
    logic [ROW_W-1:0]   cursor_row_next;
    logic [COL_W-1:0]   cursor_col_reg;
    logic [COL_W-1:0]   cursor_col_next;
    logic [COLOR_W-1:0] fg_reg;
    logic [COLOR_W-1:0] bg_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    result_t            out_reg;
    result_t            out_next;
    logic [IDX_W-1:0]   cursor_index;
    logic [ATTR_W-1:0]  cur_attr;
    logic [ROW_W-1:0]   row_inc;
    logic [ROW_W-1:0]   row_dec;

    assign cursor_index = IDX_W'(cursor_row_reg) * IDX_W'(COLUMNS) + IDX_W'(cursor_col_reg);
    assign cur_attr     = {bg_reg, fg_reg};
    assign row_inc      = (cursor_row_reg == ROW_LAST) ? '0 : cursor_row_reg + 1'b1;
    assign row_dec      = (cursor_row_reg == '0) ? ROW_LAST : cursor_row_reg - 1'b1;

    // Take the head entry when the output register is free or being drained
    assign pop = !head_i.empty && (!out_valid_reg || res.ready);

    always_comb
    begin
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        out_next        = '0;
        unique case (head_i.entry.kind)
            K_PUT:
            begin
                out_next.write_enable = 1'b1;
                out_next.cell_index   = cursor_index;
                out_next.cell_char    = head_i.entry.ch;
                out_next.cell_attr    = cur_attr;
                if (cursor_col_reg == COL_LAST)
                begin
                    cursor_col_next = '0;
                    cursor_row_next = row_inc;
                end
                else
                begin
                    cursor_col_next = cursor_col_reg + 1'b1;
                end
            end
            K_NEWLINE:
            begin
                cursor_col_next = '0;
                cursor_row_next = row_inc;
            end
            K_BACK:
            begin
                out_next.write_enable = 1'b1;
                out_next.cell_index   = cursor_index;
                out_next.cell_char    = BLANK_BYTE;
                out_next.cell_attr    = cur_attr;
                if (cursor_col_reg == '0)
                begin
                    cursor_col_next = COL_LAST;
                    cursor_row_next = row_dec;
                end
                else
                begin
                    cursor_col_next = cursor_col_reg - 1'b1;
                end
            end
            K_AT:
            begin
                out_next.write_enable = 1'b1;
                out_next.cell_index   = head_i.entry.at_index;
                out_next.cell_char    = head_i.entry.ch;
                out_next.cell_attr    = head_i.entry.at_attr;
            end
            K_SKIP:
            begin
                out_next.write_enable = 1'b0;
            end
            K_CLEAR:
            begin
                out_next.clear_request = 1'b1;
                cursor_row_next        = '0;
                cursor_col_next        = '0;
            end
            default:
            begin
                out_next.write_enable = 1'b0;
            end
        endcase
        out_next.cursor_row_out = cursor_row_next;
        out_next.cursor_col_out = cursor_col_next;

        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
            fg_reg         <= FG_RESET;
            bg_reg         <= BG_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                cursor_row_reg <= cursor_row_next;
                cursor_col_reg <= cursor_col_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_FOREGROUND: fg_reg <= cfg_data;
                    CFG_BACKGROUND: bg_reg <= cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= out_next;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.write_enable   = out_reg.write_enable;
    assign res.cell_index     = out_reg.cell_index;
    assign res.cell_char      = out_reg.cell_char;
    assign res.cell_attr      = out_reg.cell_attr;
    assign res.clear_request  = out_reg.clear_request;
    assign res.cursor_row_out = out_reg.cursor_row_out;
    assign res.cursor_col_out = out_reg.cursor_col_out;

    a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(cursor_row_reg) < ROWS) && (32'(cursor_col_reg) < COLUMNS))
        else $error("cursor off screen");

    a_result_tracks_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.cursor_row_out == cursor_row_reg
                           && out_reg.cursor_col_out == cursor_col_reg))
        else $error("shown cursor differs from cursor register");

    a_clear_homes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.clear_request) |->
            (!out_reg.write_enable && cursor_row_reg == '0 && cursor_col_reg == '0))
        else $error("clear result without home cursor");

    a_idle_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.write_enable) |->
            (out_reg.cell_index == '0 && out_reg.cell_char == '0 && out_reg.cell_attr == '0))
        else $error("write fields not zero without a write");

endmodule

`default_nettype wire
